// ===== rtl/core/lctsr_pkg.sv =====
// ----------------------------------------------------------------------------
// lctsr_pkg: shared types and constants for the load-cell tare/scale block
// Widths, register indexes, reset values, command codes and the structs that
// travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package lctsr_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int WEIGHT_BITS   = 24;
  localparam int DIV_BITS      = 16;
  localparam int THR_BITS      = 24;
  localparam int IVL_BITS      = 8;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_DIVISOR    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANGE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REPORT_INTERVAL  = 2'd2;

  localparam logic [DIV_BITS-1:0] DIVISOR_RST   = 16'd213;
  localparam logic [THR_BITS-1:0] THRESHOLD_RST = 24'd10;
  localparam logic [IVL_BITS-1:0] INTERVAL_RST  = 8'd200;

  localparam logic CMD_TARE    = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  // Sign bit of the sample; flipping it gives offset binary
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] value;
  } lctsr_entry_t;

  // Queue slot with its valid flag: push request or queue head
  typedef struct packed {
    logic         valid;
    lctsr_entry_t entry;
  } lctsr_slot_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] scale_divisor;
    logic [THR_BITS-1:0] change_threshold;
    logic [IVL_BITS-1:0] report_interval;
  } lctsr_cfg_t;

endpackage

// ===== rtl/core/lctsr_ifs.sv =====
// ----------------------------------------------------------------------------
// lctsr channel interfaces
// Valid/ready channels for sample words in and weight words out.
// ----------------------------------------------------------------------------
interface lctsr_in_if import lctsr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, command, raw_sample, input ready);
  modport sink   (input valid, command, raw_sample, output ready);
endinterface

interface lctsr_out_if import lctsr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   report;

  modport source (output valid, weight, report, input ready);
  modport sink   (input valid, weight, report, output ready);
endinterface

// ===== rtl/core/lctsr_front.sv =====
// ----------------------------------------------------------------------------
// lctsr_front: input word intake
// Accept sample words while the queue has room, convert to offset binary and
// tag each with its command.
// ----------------------------------------------------------------------------
module lctsr_front import lctsr_pkg::*; (
  input  logic        rst_n,
  lctsr_in_if.sink    in_ch,
  input  logic        q_full,
  output lctsr_slot_t q_push
);

  logic accept;

  assign in_ch.ready = rst_n & ~q_full;
  assign accept      = in_ch.valid & in_ch.ready;

  always_comb begin
    q_push.valid       = accept;
    q_push.entry.cmd   = (in_ch.command == CMD_MEASURE) ? CMD_MEASURE : CMD_TARE;
    q_push.entry.value = $unsigned(in_ch.raw_sample) ^ SAMPLE_SIGN;
  end

endmodule

// ===== rtl/core/lctsr_queue.sv =====
// ----------------------------------------------------------------------------
// lctsr_queue: short FIFO between intake and processing
// Decouple the front end from the divider so each side stalls on its own.
// ----------------------------------------------------------------------------
module lctsr_queue import lctsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lctsr_slot_t          q_push,
  input  logic                 q_pop,
  output lctsr_slot_t          q_head,
  output logic                 q_full,
  output logic [QCNT_BITS-1:0] q_count
);

  lctsr_entry_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 do_push, do_pop;

  assign do_push = q_push.valid & (count_r != QCNT_BITS'(QUEUE_DEPTH));
  assign do_pop  = q_pop & (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];
  assign q_full       = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign q_count      = count_r;

endmodule

// ===== rtl/core/lctsr_back.sv =====
// ----------------------------------------------------------------------------
// lctsr_back: tare, scaling divider and report decision
// Take one queued word at a time, run a radix-2 restoring divider, update the
// weight and report state, and hand the result to the output register.
// ----------------------------------------------------------------------------
module lctsr_back import lctsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lctsr_cfg_t  cfg,
  input  lctsr_slot_t q_head,
  output logic        q_pop,
  lctsr_out_if.source out_ch
);

  localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);
  localparam int QW       = (SAMPLE_BITS > WEIGHT_BITS) ? SAMPLE_BITS : WEIGHT_BITS;
  localparam logic [WEIGHT_BITS-1:0] W_MAX = {WEIGHT_BITS{1'b1}};

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_SCALE  = 3'd2;
  localparam logic [2:0] ST_DIFF   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] tare_r, tare_nxt;
  logic [WEIGHT_BITS-1:0] cur_w_r, cur_w_nxt;
  logic [WEIGHT_BITS-1:0] last_w_r, last_w_nxt;
  logic [IVL_BITS-1:0]    idle_r, idle_nxt;
  logic                   res_report_r, res_report_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [DIV_BITS-1:0]    rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] quo_r, quo_nxt;
  logic [DIV_BITS-1:0]    div_r, div_nxt;
  logic [WEIGHT_BITS-1:0] diff_r, diff_nxt;
  logic [WEIGHT_BITS-1:0] out_weight_r, out_weight_nxt;
  logic                   out_report_r, out_report_nxt;

  logic [DIV_BITS:0]      trial;
  logic                   trial_ge;
  logic [QW-1:0]          quo_ext;
  logic [IVL_BITS-1:0]    idle_inc;
  logic                   rep;
  logic                   out_free;

  assign trial    = {rem_r, quo_r[SAMPLE_BITS-1]};
  assign trial_ge = (trial >= {1'b0, div_r});
  assign quo_ext  = QW'(quo_r);
  assign idle_inc = idle_r + 1'b1;
  assign rep      = (diff_r >= cfg.change_threshold) || (idle_inc >= cfg.report_interval);
  assign out_free = ~out_valid_r | out_ch.ready;
  assign q_pop    = (state_r == ST_IDLE) & q_head.valid;

  always_comb begin
    state_nxt      = state_r;
    tare_nxt       = tare_r;
    cur_w_nxt      = cur_w_r;
    last_w_nxt     = last_w_r;
    idle_nxt       = idle_r;
    res_report_nxt = res_report_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_nxt        = div_r;
    diff_nxt       = diff_r;
    out_weight_nxt = out_weight_r;
    out_report_nxt = out_report_r;
    out_valid_nxt  = out_valid_r & ~out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          if (q_head.entry.cmd == CMD_TARE) begin
            tare_nxt       = q_head.entry.value;
            res_report_nxt = 1'b0;
            state_nxt      = ST_EMIT;
          end else if (q_head.entry.value > tare_r) begin
            quo_nxt   = q_head.entry.value - tare_r;
            rem_nxt   = '0;
            div_nxt   = (cfg.scale_divisor == '0) ? DIV_BITS'(1) : cfg.scale_divisor;
            cnt_nxt   = CNT_BITS'(SAMPLE_BITS);
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle
        rem_nxt = trial_ge ? DIV_BITS'(trial - {1'b0, div_r}) : DIV_BITS'(trial);
        quo_nxt = {quo_r[SAMPLE_BITS-2:0], trial_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cur_w_nxt = (quo_ext > QW'(W_MAX)) ? W_MAX : WEIGHT_BITS'(quo_ext);
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        diff_nxt  = (cur_w_r >= last_w_r) ? cur_w_r - last_w_r : last_w_r - cur_w_r;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        res_report_nxt = rep;
        if (rep) begin
          last_w_nxt = cur_w_r;
          idle_nxt   = '0;
        end else begin
          idle_nxt = idle_inc;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_weight_nxt = cur_w_r;
          out_report_nxt = res_report_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tare_r       <= '0;
      cur_w_r      <= '0;
      last_w_r     <= '0;
      idle_r       <= '0;
      res_report_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tare_r       <= tare_nxt;
      cur_w_r      <= cur_w_nxt;
      last_w_r     <= last_w_nxt;
      idle_r       <= idle_nxt;
      res_report_r <= res_report_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    div_r        <= div_nxt;
    diff_r       <= diff_nxt;
    out_weight_r <= out_weight_nxt;
    out_report_r <= out_report_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.weight = out_weight_r;
  assign out_ch.report = out_report_r;

endmodule

// ===== rtl/core/load_cell_tare_scale_report.sv =====
// ----------------------------------------------------------------------------
// load_cell_tare_scale_report: load-cell tare, scaling and change report
// Intake, two-word queue and a sequential back end with a restoring divider.
// ----------------------------------------------------------------------------
// Each word on in_ch carries a two's-complement converter sample and a
// command. The sign bit is flipped to offset binary. A tare word stores that
// value as the tare offset and returns the unchanged weight with report low.
// A measure word above the tare sets weight = (value - tare) / scale_divisor
// (truncating; a zero divisor acts as one), otherwise the old weight stays;
// then report goes high when |weight - last reported| reaches
// change_threshold or when the idle count reaches report_interval, which
// resets the idle count and latches the last reported weight. Every input
// word gives exactly one output word, in order. The back end works on one
// word at a time: a measure word above tare runs the divider, one quotient
// bit per cycle, and a scale step; every measure word then runs difference
// and decide, and every word ends in emit. The two-word queue keeps in_ch
// ready while the back end is busy, until both slots are full, and the
// output register lets the next word start while a result waits on out_ch.
// Configuration writes take effect on the next word and belong to idle time.
// ----------------------------------------------------------------------------
module load_cell_tare_scale_report import lctsr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  lctsr_in_if.sink                 in_ch,
  lctsr_out_if.source              out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  lctsr_cfg_t           cfg_r, cfg_nxt;
  lctsr_slot_t          q_push;
  lctsr_slot_t          q_head;
  logic                 q_pop;
  logic                 q_full;
  logic [QCNT_BITS-1:0] q_count;

  // Register file: indexes past the list drop silently
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_DIVISOR:    cfg_nxt.scale_divisor    = cfg_wdata[DIV_BITS-1:0];
        REG_CHANGE_THRESHOLD: cfg_nxt.change_threshold = cfg_wdata[THR_BITS-1:0];
        REG_REPORT_INTERVAL:  cfg_nxt.report_interval  = cfg_wdata[IVL_BITS-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_divisor    <= DIVISOR_RST;
      cfg_r.change_threshold <= THRESHOLD_RST;
      cfg_r.report_interval  <= INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Intake: classify and convert, push into the queue
  lctsr_front u_front (
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  lctsr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_full  (q_full),
    .q_count (q_count)
  );

  // Processing: tare, divide, decide, drive out_ch
  lctsr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> !q_full)
    else $error("push into full queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push.valid && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
    else $error("accepted word lost before queue");
`endif

endmodule
